### hw/rtl/assert_macros.svh
// assertion macros used by the counters core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

### hw/rtl/fdac_pkg.sv
// types, codes and constants of the flash die access counters
`timescale 1ns / 1ps
package fdac_pkg;
  localparam int MaxDiesDef   = 64;
  localparam int MaxBlocksDef = 1024;
  localparam int MapDepth     = 64;
  localparam int AduW         = 32;
  localparam int PageW        = 16;
  localparam int CtrW         = 64;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 16;

  localparam logic [15:0] PageAdusRst  = 16'd1;
  localparam logic [6:0]  VdDiesRst    = 7'd1;
  localparam logic [10:0] BlocksRst    = 11'd1024;
  localparam logic        HeatEnRst    = 1'b1;
  localparam logic [6:0]  VdDiesMax    = 7'd64;

  typedef enum logic [1:0] {
    KIND_LOAD, KIND_WRITE, KIND_READ, KIND_QUERY
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK, ST_INVALID, ST_RANGE
  } status_e;

  typedef enum logic [1:0] {
    REG_PAGE_ADUS, REG_VD_DIES, REG_BLOCKS, REG_HEAT_EN
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV1_GO, S_DIV1_WAIT, S_DIV2_GO, S_DIV2_WAIT,
    S_MAP, S_CNT, S_UPD, S_QRD, S_QCAP, S_DONE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [AduW-1:0]  dividend;
    logic [PageW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [AduW-1:0]  quot;
    logic [PageW-1:0] rem;
  } div_rsp_t;
endpackage

### hw/rtl/fdac_if.sv
// handshake channels of the flash die access counters
`timescale 1ns / 1ps
interface fdac_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        addr_valid;
  logic [9:0]  block_number;
  logic [31:0] adu_offset;
  logic [7:0]  access_count;
  logic        last_of_batch;
  logic [5:0]  map_slot;
  logic [5:0]  die_id;
  logic [1:0]  query_select;
  logic [15:0] query_index;
  modport source (output valid, kind, addr_valid, block_number, adu_offset, access_count,
                  last_of_batch, map_slot, die_id, query_select, query_index,
                  input ready);
  modport sink (input valid, kind, addr_valid, block_number, adu_offset, access_count,
                last_of_batch, map_slot, die_id, query_select, query_index,
                output ready);
endinterface

interface fdac_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] counter_value;
  logic        batch_done;
  modport source (output valid, status, counter_value, batch_done, input ready);
  modport sink (input valid, status, counter_value, batch_done, output ready);
endinterface

interface fdac_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fdac_pkg::CfgIdxW-1:0]    index;
  logic [fdac_pkg::CfgDataW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/fdac_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module fdac_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### hw/rtl/fdac_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module fdac_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fdac_pkg::div_req_t req_i,
  output fdac_pkg::div_rsp_t rsp_o
);
  localparam int AW = fdac_pkg::AduW;
  localparam int PW = fdac_pkg::PageW;

  logic          busy_q, done_q;
  logic [4:0]    cnt_q;
  logic [AW-1:0] dvd_q;
  logic [PW-1:0] dvs_q, rem_q;
  logic [PW:0]   trial, diff;
  logic          ge;

  assign trial = {rem_q, dvd_q[AW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[PW-1:0] : trial[PW-1:0];
      dvd_q <= {dvd_q[AW-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;
endmodule

### hw/rtl/flash_die_access_counters_core.sv
// flash die access counters: sequencer, counter stores and shared divider
//
//   channel | dir | handshake     | payload
//   in_i    | in  | valid / ready | kind, address, burst, map load, query
//   out_o   | out | valid / ready | status, counter_value, batch_done
//   cfg_i   | in  | valid / ready | register index, data
//
// load goes straight to the result; query reads the counter rams and then
// captures the value. a write, or a read burst of nonzero count, with a valid
// address runs two passes of the shared divider, then map, count and update
// steps per adu. after reset a clearing pass zeroes both counter rams; no item
// is taken meanwhile. a finished result waits in the output register; a
// further result holds the sequencer until the output register is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module flash_die_access_counters_core #(
  parameter int MAX_DIES   = fdac_pkg::MaxDiesDef,
  parameter int MAX_BLOCKS = fdac_pkg::MaxBlocksDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fdac_in_if.sink    in_i,
  fdac_out_if.source out_o,
  fdac_cfg_if.sink   cfg_i
);
  localparam int HeatDepth = MAX_DIES * MAX_BLOCKS;
  localparam int DIW       = (MAX_DIES > 1) ? $clog2(MAX_DIES) : 1;
  localparam int HIW       = (HeatDepth > 1) ? $clog2(HeatDepth) : 1;
  localparam int DieRamD   = 2 ** (DIW + 1);
  localparam int HeatRamD  = 2 ** (HIW + 1);
  localparam int CW        = fdac_pkg::CtrW;

  fdac_pkg::state_e state_q, state_d;

  // configuration
  logic [15:0] page_adus_q;
  logic [6:0]  vd_dies_q;
  logic [10:0] blocks_q;
  logic        heat_en_q;
  logic [15:0] pa_eff;
  logic [6:0]  nd_eff;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_adus_q <= fdac_pkg::PageAdusRst;
      vd_dies_q   <= fdac_pkg::VdDiesRst;
      blocks_q    <= fdac_pkg::BlocksRst;
      heat_en_q   <= fdac_pkg::HeatEnRst;
    end else if (cfg_i.valid) begin
      case (fdac_pkg::cfg_reg_e'(cfg_i.index))
        fdac_pkg::REG_PAGE_ADUS: page_adus_q <= cfg_i.data;
        fdac_pkg::REG_VD_DIES:   vd_dies_q   <= cfg_i.data[6:0];
        fdac_pkg::REG_BLOCKS:    blocks_q    <= cfg_i.data[10:0];
        fdac_pkg::REG_HEAT_EN:   heat_en_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign pa_eff = (page_adus_q == '0) ? 16'd1 : page_adus_q;
  assign nd_eff = (vd_dies_q == '0) ? 7'd1 :
                  (vd_dies_q > fdac_pkg::VdDiesMax) ? fdac_pkg::VdDiesMax : vd_dies_q;

  // item registers
  logic        in_acc;
  logic        wr_q;
  logic [9:0]  blk_q;
  logic [31:0] adu_q, q_q;
  logic [8:0]  cnt_q;
  logic [15:0] r_q;
  logic [5:0]  qm_q;
  logic [1:0]  qsel_q;
  logic [15:0] qidx_q;
  logic        qok_q;
  logic        die_ok_q, heat_ok_q;
  logic [DIW-1:0] die_idx_q;
  logic [HIW-1:0] hidx_q;
  logic [1:0]  res_status_q;
  logic [CW-1:0] res_value_q;
  logic        res_done_q;
  logic [HIW:0] clr_q;

  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [CW-1:0] out_value_q;
  logic        out_done_q;
  logic        out_load;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_load = (state_q == fdac_pkg::S_DONE) && (!out_valid_q || out_o.ready);

  // divider
  fdac_pkg::div_req_t div_req;
  fdac_pkg::div_rsp_t div_rsp;

  fdac_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // rams
  logic [5:0]            map_rdata;
  logic                  die_we, heat_we;
  logic [DIW:0]          die_waddr, die_raddr;
  logic [HIW:0]          heat_waddr, heat_raddr;
  logic [CW-1:0]         die_wdata, heat_wdata, die_rdata, heat_rdata;

  fdac_ram #(.Width(6), .Depth(fdac_pkg::MapDepth)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (fdac_pkg::kind_e'(in_i.kind) == fdac_pkg::KIND_LOAD)),
    .waddr_i (in_i.map_slot),
    .wdata_i (in_i.die_id),
    .raddr_i (qm_q),
    .rdata_o (map_rdata)
  );

  fdac_ram #(.Width(CW), .Depth(DieRamD)) u_die_ram (
    .clk_i   (clk_i),
    .we_i    (die_we),
    .waddr_i (die_waddr),
    .wdata_i (die_wdata),
    .raddr_i (die_raddr),
    .rdata_o (die_rdata)
  );

  fdac_ram #(.Width(CW), .Depth(HeatRamD)) u_heat_ram (
    .clk_i   (clk_i),
    .we_i    (heat_we),
    .waddr_i (heat_waddr),
    .wdata_i (heat_wdata),
    .raddr_i (heat_raddr),
    .rdata_o (heat_rdata)
  );

  // per-adu lookup from the map output
  logic [31:0] die32, blk32, hidx32, qidx32;
  logic        die_ok, heat_ok, adu_bad, qok;

  assign die32   = 32'(map_rdata);
  assign blk32   = 32'(blk_q);
  assign hidx32  = die32 * 32'(blocks_q) + blk32;
  assign die_ok  = die32 < 32'(MAX_DIES);
  assign heat_ok = die_ok && heat_en_q && (blk32 < 32'(blocks_q)) &&
                   (blk32 < 32'(MAX_BLOCKS)) && (hidx32 < 32'(HeatDepth));
  assign adu_bad = !die_ok || (heat_en_q && !heat_ok);
  assign qidx32  = 32'(qidx_q);
  assign qok     = qsel_q[1] ? (qidx32 < 32'(HeatDepth)) : (qidx32 < 32'(MAX_DIES));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fdac_pkg::S_CLEAR: if (&clr_q) state_d = fdac_pkg::S_IDLE;
      fdac_pkg::S_IDLE: begin
        if (in_acc) begin
          case (fdac_pkg::kind_e'(in_i.kind))
            fdac_pkg::KIND_LOAD:  state_d = fdac_pkg::S_DONE;
            fdac_pkg::KIND_WRITE: state_d = in_i.addr_valid ? fdac_pkg::S_DIV1_GO
                                                            : fdac_pkg::S_DONE;
            fdac_pkg::KIND_READ: begin
              state_d = (in_i.addr_valid && in_i.access_count != '0) ?
                        fdac_pkg::S_DIV1_GO : fdac_pkg::S_DONE;
            end
            fdac_pkg::KIND_QUERY: state_d = fdac_pkg::S_QRD;
            default:              state_d = fdac_pkg::S_DONE;
          endcase
        end
      end
      fdac_pkg::S_DIV1_GO:   state_d = fdac_pkg::S_DIV1_WAIT;
      fdac_pkg::S_DIV1_WAIT: if (div_rsp.done) state_d = fdac_pkg::S_DIV2_GO;
      fdac_pkg::S_DIV2_GO:   state_d = fdac_pkg::S_DIV2_WAIT;
      fdac_pkg::S_DIV2_WAIT: if (div_rsp.done) state_d = fdac_pkg::S_MAP;
      fdac_pkg::S_MAP:       state_d = fdac_pkg::S_CNT;
      fdac_pkg::S_CNT:       state_d = fdac_pkg::S_UPD;
      fdac_pkg::S_UPD: state_d = (cnt_q == 9'd1) ? fdac_pkg::S_DONE : fdac_pkg::S_MAP;
      fdac_pkg::S_QRD:       state_d = fdac_pkg::S_QCAP;
      fdac_pkg::S_QCAP:      state_d = fdac_pkg::S_DONE;
      fdac_pkg::S_DONE:      if (out_load) state_d = fdac_pkg::S_IDLE;
      default:               state_d = fdac_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_i.ready       = (state_q == fdac_pkg::S_IDLE);
    div_req.start    = 1'b0;
    div_req.dividend = adu_q;
    div_req.divisor  = pa_eff;
    die_we     = 1'b0;
    die_waddr  = {wr_q, die_idx_q};
    die_wdata  = die_rdata + 64'd1;
    die_raddr  = {wr_q, die32[DIW-1:0]};
    heat_we    = 1'b0;
    heat_waddr = {wr_q, hidx_q};
    heat_wdata = heat_rdata + 64'd1;
    heat_raddr = {wr_q, hidx32[HIW-1:0]};
    case (state_q)
      fdac_pkg::S_CLEAR: begin
        die_we     = 1'b1;
        die_waddr  = clr_q[DIW:0];
        die_wdata  = '0;
        heat_we    = 1'b1;
        heat_waddr = clr_q;
        heat_wdata = '0;
      end
      fdac_pkg::S_DIV1_GO: div_req.start = 1'b1;
      fdac_pkg::S_DIV2_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = q_q;
        div_req.divisor  = 16'(nd_eff);
      end
      fdac_pkg::S_UPD: begin
        die_we  = die_ok_q;
        heat_we = heat_ok_q;
      end
      fdac_pkg::S_QRD: begin
        die_raddr  = {qsel_q[0], qidx32[DIW-1:0]};
        heat_raddr = {qsel_q[0], qidx32[HIW-1:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fdac_pkg::S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == fdac_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      wr_q         <= (fdac_pkg::kind_e'(in_i.kind) == fdac_pkg::KIND_WRITE);
      blk_q        <= in_i.block_number;
      adu_q        <= in_i.adu_offset;
      cnt_q        <= (fdac_pkg::kind_e'(in_i.kind) == fdac_pkg::KIND_WRITE) ? 9'd1
                      : 9'(in_i.access_count);
      qsel_q       <= in_i.query_select;
      qidx_q       <= in_i.query_index;
      res_value_q  <= '0;
      res_done_q   <= (fdac_pkg::kind_e'(in_i.kind) == fdac_pkg::KIND_WRITE) &&
                      in_i.last_of_batch;
      res_status_q <= ((fdac_pkg::kind_e'(in_i.kind) == fdac_pkg::KIND_WRITE ||
                        fdac_pkg::kind_e'(in_i.kind) == fdac_pkg::KIND_READ) &&
                       !in_i.addr_valid) ? fdac_pkg::ST_INVALID : fdac_pkg::ST_OK;
    end
    if (state_q == fdac_pkg::S_DIV1_WAIT && div_rsp.done) begin
      q_q <= div_rsp.quot;
      r_q <= div_rsp.rem;
    end
    if (state_q == fdac_pkg::S_DIV2_WAIT && div_rsp.done) qm_q <= div_rsp.rem[5:0];
    if (state_q == fdac_pkg::S_CNT) begin
      die_ok_q  <= die_ok;
      heat_ok_q <= heat_ok;
      die_idx_q <= die32[DIW-1:0];
      hidx_q    <= hidx32[HIW-1:0];
      if (adu_bad) res_status_q <= fdac_pkg::ST_RANGE;
    end
    if (state_q == fdac_pkg::S_UPD) begin
      cnt_q <= cnt_q - 9'd1;
      adu_q <= adu_q + 32'd1;
      // the adu wraps to zero, which restarts page and die position
      if (&adu_q) begin
        r_q  <= '0;
        qm_q <= '0;
      end else if ({1'b0, r_q} + 17'd1 == {1'b0, pa_eff}) begin
        r_q  <= '0;
        qm_q <= (7'(qm_q) + 7'd1 == nd_eff) ? 6'd0 : qm_q + 6'd1;
      end else begin
        r_q <= r_q + 16'd1;
      end
    end
    if (state_q == fdac_pkg::S_QRD) qok_q <= qok;
    if (state_q == fdac_pkg::S_QCAP) begin
      res_status_q <= qok_q ? fdac_pkg::ST_OK : fdac_pkg::ST_RANGE;
      res_value_q  <= !qok_q ? '0 : (qsel_q[1] ? heat_rdata : die_rdata);
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_done_q   <= res_done_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.counter_value = out_value_q;
  assign out_o.batch_done    = out_done_q;

  `ASSERT_NEVER(a_no_accept_in_clear, clk_i, rst_ni,
                (state_q == fdac_pkg::S_CLEAR) && in_i.ready, "item taken during clear")
  `ASSERT_PROP(a_rem_below_page, clk_i, rst_ni,
               (state_q == fdac_pkg::S_MAP) |-> ({1'b0, r_q} < {1'b0, pa_eff}),
               "page remainder out of range")
  `ASSERT_PROP(a_die_pos_below_count, clk_i, rst_ni,
               (state_q == fdac_pkg::S_MAP) |-> (7'(qm_q) < nd_eff),
               "die position out of range")
  `ASSERT_PROP(a_done_loads_out, clk_i, rst_ni, out_load |=> out_valid_q,
               "result not presented")
  `ASSERT_NEVER(a_div_idle_at_start, clk_i, rst_ni, div_req.start && div_rsp.busy,
                "divider started while busy")
endmodule
